FILE: rtl/scc_pkg.sv
package scc_pkg;

  localparam int ENTRIES_DEF     = 64;
  localparam int SECTOR_BITS_DEF = 32;
  localparam int MAX_RESULTS     = 64;

  localparam int FUNC_W   = 2;
  localparam int SECTOR_W = 32;
  localparam int SLOT_W   = 6;

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  typedef enum logic [2:0] {
    ACT_HIT     = 3'd0,
    ACT_FILL    = 3'd1,
    ACT_CLEAR   = 3'd2,
    ACT_FLUSHED = 3'd3,
    ACT_NOTHING = 3'd4
  } action_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SECTOR_W-1:0] sector;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    action_t             action;
    logic                writeback;
    logic [SECTOR_W-1:0] writeback_sector;
    logic                last;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_HIT,
    ST_ALLOC,
    ST_SWRD,
    ST_SWEV,
    ST_FLRD,
    ST_FLEV,
    ST_FLEND,
    ST_EMIT_END,
    ST_EMIT_FL
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_HIT_LATCH,
    OP_HIT_WR,
    OP_ALLOC,
    OP_HAND_RD,
    OP_REF_CLR,
    OP_VICTIM,
    OP_FL_TAKE,
    OP_FL_END,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic rd_vld;
    logic hit;
    logic rd_ref;
    logic rd_dirty;
    logic scan_end;
    logic full;
    logic cnt_max;
    logic pend_vld;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/scc_ctrl.sv
module scc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [scc_pkg::FUNC_W-1:0]  func,
  input  scc_pkg::status_t            st,
  output scc_pkg::cmd_t               cmd,
  output logic                        req_stall
);

  scc_pkg::state_t state;
  scc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = scc_pkg::OP_NONE;
    req_stall  = 1'b1;
    case (state)
      scc_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          case (func)
            scc_pkg::FUNC_READ, scc_pkg::FUNC_WRITE: begin
              cmd.op     = scc_pkg::OP_LOAD;
              state_next = scc_pkg::ST_LOOK;
            end
            scc_pkg::FUNC_FLUSH: begin
              cmd.op     = scc_pkg::OP_LOAD;
              state_next = scc_pkg::ST_FLRD;
            end
            default: state_next = scc_pkg::ST_IDLE;
          endcase
        end
      end
      scc_pkg::ST_LOOK: begin
        // Reads are issued one slot per cycle; each compare sees the data
        // of the read issued in the cycle before.
        if (st.rd_vld && st.hit) begin
          cmd.op     = scc_pkg::OP_HIT_LATCH;
          state_next = scc_pkg::ST_HIT;
        end else if (!st.scan_end) begin
          cmd.op = scc_pkg::OP_SCAN;
        end else if (!st.rd_vld) begin
          state_next = st.full ? scc_pkg::ST_SWRD : scc_pkg::ST_ALLOC;
        end
      end
      scc_pkg::ST_HIT: begin
        cmd.op     = scc_pkg::OP_HIT_WR;
        state_next = scc_pkg::ST_EMIT_END;
      end
      scc_pkg::ST_ALLOC: begin
        cmd.op     = scc_pkg::OP_ALLOC;
        state_next = scc_pkg::ST_EMIT_END;
      end
      scc_pkg::ST_SWRD: begin
        cmd.op     = scc_pkg::OP_HAND_RD;
        state_next = scc_pkg::ST_SWEV;
      end
      scc_pkg::ST_SWEV: begin
        if (st.rd_ref) begin
          cmd.op     = scc_pkg::OP_REF_CLR;
          state_next = scc_pkg::ST_SWRD;
        end else begin
          cmd.op     = scc_pkg::OP_VICTIM;
          state_next = scc_pkg::ST_EMIT_END;
        end
      end
      scc_pkg::ST_FLRD: begin
        if (st.scan_end || st.cnt_max) begin
          state_next = scc_pkg::ST_FLEND;
        end else begin
          cmd.op     = scc_pkg::OP_SCAN;
          state_next = scc_pkg::ST_FLEV;
        end
      end
      scc_pkg::ST_FLEV: begin
        // A dirty slot is held back one step so that the final one can be
        // marked as the last item of the flush.
        if (st.rd_dirty) begin
          cmd.op     = scc_pkg::OP_FL_TAKE;
          state_next = st.pend_vld ? scc_pkg::ST_EMIT_FL : scc_pkg::ST_FLRD;
        end else begin
          state_next = scc_pkg::ST_FLRD;
        end
      end
      scc_pkg::ST_FLEND: begin
        cmd.op     = scc_pkg::OP_FL_END;
        state_next = scc_pkg::ST_EMIT_END;
      end
      scc_pkg::ST_EMIT_END: begin
        if (st.out_free) begin
          cmd.op     = scc_pkg::OP_EMIT;
          state_next = scc_pkg::ST_IDLE;
        end
      end
      scc_pkg::ST_EMIT_FL: begin
        if (st.out_free) begin
          cmd.op     = scc_pkg::OP_EMIT;
          state_next = scc_pkg::ST_FLRD;
        end
      end
      default: state_next = scc_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/scc_datapath.sv
module scc_datapath #(
  parameter int ENTRIES     = scc_pkg::ENTRIES_DEF,
  parameter int SECTOR_BITS = scc_pkg::SECTOR_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  scc_pkg::req_t    req,
  input  scc_pkg::cmd_t    cmd,
  output scc_pkg::status_t st,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output scc_pkg::rsp_t    rsp
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int TW = (SECTOR_BITS < scc_pkg::SECTOR_W) ? SECTOR_BITS : scc_pkg::SECTOR_W;
  localparam int MW = TW + 2;
  localparam int NW = $clog2(scc_pkg::MAX_RESULTS + 1);

  // Each tag RAM word holds the sector tag, the dirty bit and the
  // reference bit. Slots below the fill count are the valid ones.
  logic [MW-1:0] mem [ENTRIES];

  logic          is_write;
  logic [TW-1:0] req_tag;
  logic [CW-1:0] idx;
  logic [CW-1:0] fill;
  logic [AW-1:0] hand;
  logic [AW-1:0] hand_inc;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  logic [MW-1:0] rd_word;
  logic [TW-1:0] rd_tag;
  logic          rd_dirty;
  logic          rd_ref;
  logic [AW-1:0] hit_slot;
  logic          hit_dirty;
  logic          pend_vld;
  logic [AW-1:0] pend_slot;
  logic [TW-1:0] pend_tag;
  logic [NW-1:0] cnt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_word;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  scc_pkg::rsp_t    res;
  scc_pkg::rsp_t    res_next;
  logic             res_ld;
  scc_pkg::action_t miss_act;

  assign rd_tag   = rd_word[MW-1:2];
  assign rd_dirty = rd_word[1];
  assign rd_ref   = rd_word[0];
  assign hand_inc = (hand == AW'(ENTRIES - 1)) ? '0 : hand + AW'(1);
  assign miss_act = is_write ? scc_pkg::ACT_CLEAR : scc_pkg::ACT_FILL;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hand;
    wr_word = {req_tag, is_write, 1'b1};
    rd_en   = 1'b0;
    rd_addr = hand;
    case (cmd.op)
      scc_pkg::OP_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = idx[AW-1:0];
      end
      scc_pkg::OP_HAND_RD: begin
        rd_en = 1'b1;
      end
      scc_pkg::OP_HIT_WR: begin
        wr_en   = 1'b1;
        wr_addr = hit_slot;
        wr_word = {req_tag, hit_dirty | is_write, 1'b1};
      end
      scc_pkg::OP_ALLOC: begin
        wr_en   = 1'b1;
        wr_addr = fill[AW-1:0];
      end
      scc_pkg::OP_REF_CLR: begin
        wr_en   = 1'b1;
        wr_word = {rd_tag, rd_dirty, 1'b0};
      end
      scc_pkg::OP_VICTIM: begin
        wr_en = 1'b1;
      end
      scc_pkg::OP_FL_TAKE: begin
        wr_en   = 1'b1;
        wr_addr = rd_idx;
        wr_word = {rd_tag, 1'b0, rd_ref};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_comb begin
    res_ld                    = 1'b1;
    res_next.slot             = scc_pkg::SLOT_W'(hit_slot);
    res_next.action           = scc_pkg::ACT_HIT;
    res_next.writeback        = 1'b0;
    res_next.writeback_sector = '0;
    res_next.last             = 1'b1;
    case (cmd.op)
      scc_pkg::OP_HIT_WR: begin
        res_next.slot = scc_pkg::SLOT_W'(hit_slot);
      end
      scc_pkg::OP_ALLOC: begin
        res_next.slot   = scc_pkg::SLOT_W'(fill[AW-1:0]);
        res_next.action = miss_act;
      end
      scc_pkg::OP_VICTIM: begin
        res_next.slot             = scc_pkg::SLOT_W'(hand);
        res_next.action           = miss_act;
        res_next.writeback        = rd_dirty;
        res_next.writeback_sector = rd_dirty ? scc_pkg::SECTOR_W'(rd_tag) : '0;
      end
      scc_pkg::OP_FL_TAKE: begin
        res_ld                    = pend_vld;
        res_next.slot             = scc_pkg::SLOT_W'(pend_slot);
        res_next.action           = scc_pkg::ACT_FLUSHED;
        res_next.writeback        = 1'b1;
        res_next.writeback_sector = scc_pkg::SECTOR_W'(pend_tag);
        res_next.last             = 1'b0;
      end
      scc_pkg::OP_FL_END: begin
        if (pend_vld) begin
          res_next.slot             = scc_pkg::SLOT_W'(pend_slot);
          res_next.action           = scc_pkg::ACT_FLUSHED;
          res_next.writeback        = 1'b1;
          res_next.writeback_sector = scc_pkg::SECTOR_W'(pend_tag);
        end else begin
          res_next.slot   = '0;
          res_next.action = scc_pkg::ACT_NOTHING;
        end
      end
      default: res_ld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      hand      <= '0;
      idx       <= '0;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      pend_vld  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= (cmd.op == scc_pkg::OP_SCAN);
      case (cmd.op)
        scc_pkg::OP_LOAD: begin
          idx      <= '0;
          cnt      <= '0;
          pend_vld <= 1'b0;
        end
        scc_pkg::OP_SCAN:    idx  <= idx + CW'(1);
        scc_pkg::OP_ALLOC:   fill <= fill + CW'(1);
        scc_pkg::OP_REF_CLR: hand <= hand_inc;
        scc_pkg::OP_VICTIM:  hand <= hand_inc;
        scc_pkg::OP_FL_TAKE: begin
          cnt      <= cnt + NW'(1);
          pend_vld <= 1'b1;
        end
        default: cnt <= cnt;
      endcase
      if (cmd.op == scc_pkg::OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == scc_pkg::OP_LOAD) begin
      is_write <= (req.func == scc_pkg::FUNC_WRITE);
      req_tag  <= req.sector[TW-1:0];
    end
    if (cmd.op == scc_pkg::OP_SCAN) begin
      rd_idx <= idx[AW-1:0];
    end
    if (cmd.op == scc_pkg::OP_HIT_LATCH) begin
      hit_slot  <= rd_idx;
      hit_dirty <= rd_dirty;
    end
    if (cmd.op == scc_pkg::OP_FL_TAKE) begin
      pend_slot <= rd_idx;
      pend_tag  <= rd_tag;
    end
    if (res_ld) begin
      res <= res_next;
    end
    if (cmd.op == scc_pkg::OP_EMIT) begin
      rsp <= res;
    end
  end

  assign st.rd_vld   = rd_vld;
  assign st.hit      = (rd_tag == req_tag);
  assign st.rd_ref   = rd_ref;
  assign st.rd_dirty = rd_dirty;
  assign st.scan_end = (idx == fill);
  assign st.full     = (fill == CW'(ENTRIES));
  assign st.cnt_max  = (cnt == NW'(scc_pkg::MAX_RESULTS));
  assign st.pend_vld = pend_vld;
  assign st.out_free = !rsp_valid || !rsp_stall;

endmodule

FILE: rtl/sector_cache_clock_controller.sv
// Tag and replacement controller for a fully associative write-back
// sector cache. A request item on req (read, write or flush) is taken when
// req_valid is high and req_stall is low; result items leave on rsp under
// rsp_valid and rsp_stall, with last marking the final item of a request.
// One request is worked on at a time. A read or write walks the valid
// slots through the tag RAM read port at one slot per cycle; fill is the
// number of valid slots. When the cache is full, the clock sweep reads
// each slot it inspects and then updates it through the one port. A flush
// reads each valid slot in turn and sends an item for each dirty one.
// The result sits in an output register: the next request is accepted
// while it still waits, and a stalled receiver holds it unchanged while
// the controller waits for room before sending another. Reset clears the
// fill count, the clock hand and all handshakes; the tag RAM needs no
// clearing pass since only slots below the fill count are ever read.
module sector_cache_clock_controller #(
  parameter int ENTRIES     = scc_pkg::ENTRIES_DEF,
  parameter int SECTOR_BITS = scc_pkg::SECTOR_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  scc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output scc_pkg::rsp_t rsp
);

  scc_pkg::cmd_t    cmd;
  scc_pkg::status_t st;

  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .func      (req.func),
    .st        (st),
    .cmd       (cmd),
    .req_stall (req_stall)
  );

  scc_datapath #(
    .ENTRIES     (ENTRIES),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = scc_pkg::ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 108;
  localparam int TAIL_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam logic [scc_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    scc_pkg::req_t r;
    bit            drain;
  } pending_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  scc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  scc_pkg::rsp_t rsp;

  pending_req_t pend_q[$];
  scc_pkg::rsp_t cache_result_q[$];
  int req_taken = 0;
  int total_items = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;

  // Shadow copy of the cache tags and policy bits.
  logic [scc_pkg::SECTOR_W-1:0] tag_m[SLOTS];
  bit valid_m[SLOTS];
  bit dirty_m[SLOTS];
  bit ref_m[SLOTS];
  int hand_m = 0;

  sector_cache_clock_controller dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial forever #1 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic scc_pkg::rsp_t make_rsp(int slot, scc_pkg::action_t act, logic wb,
                                             logic [scc_pkg::SECTOR_W-1:0] wbs, logic last);
    scc_pkg::rsp_t res;
    res.slot = scc_pkg::SLOT_W'(slot);
    res.action = act;
    res.writeback = wb;
    res.writeback_sector = wbs;
    res.last = last;
    return res;
  endfunction

  function automatic void predict_cache_results(scc_pkg::req_t r);
    int slot;
    int victim;
    bit found;
    bit have;
    logic wb;
    logic [scc_pkg::SECTOR_W-1:0] wbs;
    scc_pkg::rsp_t held;
    slot = -1;
    have = 1'b0;
    wb = 1'b0;
    wbs = '0;
    held = '0;
    case (r.func)
      scc_pkg::FUNC_READ, scc_pkg::FUNC_WRITE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && valid_m[i] && tag_m[i] == r.sector) slot = i;
        end
        if (slot >= 0) begin
          ref_m[slot] = 1'b1;
          if (r.func == scc_pkg::FUNC_WRITE) dirty_m[slot] = 1'b1;
          cache_result_q.push_back(make_rsp(slot, scc_pkg::ACT_HIT, 1'b0, '0, 1'b1));
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot < 0 && !valid_m[i]) slot = i;
          end
          if (slot < 0) begin
            // Second-chance sweep: referenced slots lose their bit and are skipped.
            found = 1'b0;
            while (!found) begin
              victim = hand_m;
              hand_m = (hand_m + 1) % SLOTS;
              if (!ref_m[victim]) found = 1'b1;
              else ref_m[victim] = 1'b0;
            end
            slot = victim;
            if (dirty_m[slot]) begin
              wb = 1'b1;
              wbs = tag_m[slot];
            end
          end
          tag_m[slot] = r.sector;
          valid_m[slot] = 1'b1;
          ref_m[slot] = 1'b1;
          dirty_m[slot] = (r.func == scc_pkg::FUNC_WRITE);
          cache_result_q.push_back(make_rsp(slot, (r.func == scc_pkg::FUNC_WRITE) ?
                                            scc_pkg::ACT_CLEAR : scc_pkg::ACT_FILL,
                                            wb, wbs, 1'b1));
        end
      end
      scc_pkg::FUNC_FLUSH: begin
        // Each flushed slot is held back one step so the final one can carry last.
        for (int i = 0; i < SLOTS; i++) begin
          if (dirty_m[i]) begin
            if (have) cache_result_q.push_back(held);
            held = make_rsp(i, scc_pkg::ACT_FLUSHED, 1'b1, tag_m[i], 1'b0);
            have = 1'b1;
            dirty_m[i] = 1'b0;
          end
        end
        if (have) begin
          held.last = 1'b1;
          cache_result_q.push_back(held);
        end else begin
          cache_result_q.push_back(make_rsp(0, scc_pkg::ACT_NOTHING, 1'b0, '0, 1'b1));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_req(logic [scc_pkg::FUNC_W-1:0] f,
                                  logic [scc_pkg::SECTOR_W-1:0] s, bit drain);
    pending_req_t p;
    p.r.func = f;
    p.r.sector = s;
    p.drain = drain;
    pend_q.push_back(p);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!(req_valid && req_stall)) begin
      if (req_valid) begin
        predict_cache_results(req);
        req_taken++;
        tx_wait = tx_idle ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 15) == 0) tx_idle = !tx_idle;
      end
      if (tx_wait > 0) begin
        tx_wait--;
        req_valid <= 1'b0;
      end else if (pend_q.size() != 0 && (!pend_q[0].drain || cache_result_q.size() == 0)) begin
        req <= pend_q[0].r;
        pend_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    scc_pkg::rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (cache_result_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result item with none expected: slot %0d action %0d wb %0b sector %h last %0b",
                   $time, rsp.slot, rsp.action, rsp.writeback, rsp.writeback_sector, rsp.last);
        end else begin
          want = cache_result_q.pop_front();
          if (rsp.slot !== want.slot || rsp.action !== want.action ||
              rsp.writeback !== want.writeback ||
              rsp.writeback_sector !== want.writeback_sector || rsp.last !== want.last) begin
            mismatch_count++;
            $display("%0t: expected slot %0d action %0d wb %0b sector %h last %0b", $time,
                     want.slot, want.action, want.writeback, want.writeback_sector, want.last);
            $display("%0t:   actual slot %0d action %0d wb %0b sector %h last %0b", $time,
                     rsp.slot, rsp.action, rsp.writeback, rsp.writeback_sector, rsp.last);
          end
        end
        rx_wait = rx_idle ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 19) == 0) rx_idle = !rx_idle;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      rsp_stall <= (rx_wait > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int accesses;
    int pick;
    int lo;
    logic [scc_pkg::FUNC_W-1:0] f;
    logic [scc_pkg::SECTOR_W-1:0] s;
    logic [scc_pkg::SECTOR_W-1:0] seen_q[$];

    // Directed part: empty flush, extremes, hits, a dirty flush and the spare code.
    add_req(scc_pkg::FUNC_FLUSH, 32'h0000_0000, 1'b0);
    add_req(scc_pkg::FUNC_READ, 32'h0000_0000, 1'b0);
    add_req(scc_pkg::FUNC_READ, 32'h0000_0000, 1'b0);
    add_req(scc_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 1'b0);
    add_req(scc_pkg::FUNC_WRITE, 32'h0000_0000, 1'b0);
    add_req(FUNC_SPARE, 32'hFFFF_FFFF, 1'b0);
    add_req(scc_pkg::FUNC_READ, 32'hFFFF_FFFF, 1'b0);
    add_req(scc_pkg::FUNC_READ, 32'h8000_0000, 1'b0);
    add_req(scc_pkg::FUNC_WRITE, 32'h0000_0001, 1'b0);
    add_req(scc_pkg::FUNC_WRITE, 32'h7FFF_FFFF, 1'b0);
    add_req(scc_pkg::FUNC_FLUSH, 32'hFFFF_FFFF, 1'b0);
    add_req(scc_pkg::FUNC_FLUSH, 32'h0000_0000, 1'b0);
    add_req(scc_pkg::FUNC_WRITE, 32'hA5A5_A5A5, 1'b0);
    add_req(scc_pkg::FUNC_READ, 32'h5A5A_5A5A, 1'b0);
    add_req(FUNC_SPARE, 32'h0000_0000, 1'b0);
    add_req(scc_pkg::FUNC_READ, 32'hA5A5_A5A5, 1'b0);
    seen_q = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF, 32'hA5A5_A5A5,
               32'h5A5A_5A5A};

    // Random part: mostly fresh sectors to fill the cache and force sweeps,
    // with recent sectors mixed in so hits and re-fills of evicted ones occur.
    accesses = 0;
    while (accesses < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 44) f = scc_pkg::FUNC_READ;
      else if (pick < 88) f = scc_pkg::FUNC_WRITE;
      else if (pick < 95) f = scc_pkg::FUNC_FLUSH;
      else f = FUNC_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        s = $urandom();
        seen_q.push_back(s);
      end else if (pick < 92) begin
        lo = (seen_q.size() > 70) ? seen_q.size() - 70 : 0;
        s = seen_q[$urandom_range(lo, seen_q.size() - 1)];
      end else begin
        case ($urandom_range(0, 3))
          0: s = '0;
          1: s = '1;
          2: s = 32'h1 << $urandom_range(0, 31);
          default: s = ~(32'h1 << $urandom_range(0, 31));
        endcase
      end
      add_req(f, s, (accesses == 0) || ($urandom_range(0, 39) == 0));
      if (f != FUNC_SPARE) accesses++;
    end
    total_items = pend_q.size();

    do @(posedge clk); while (req_taken != total_items || cache_result_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sector_cache_clock_controller.f
rtl/scc_pkg.sv
rtl/scc_ctrl.sv
rtl/scc_datapath.sv
rtl/sector_cache_clock_controller.sv
tb/sv/tb_top.sv
